[design/polyblep_osc_adsr_voice_core_assert.svh]
// Assertion macros for the polyBLEP voice core.
// Used by the top level only; expects clk and rst_n in the including scope.
`ifndef POLYBLEP_OSC_ADSR_VOICE_CORE_ASSERT_SVH
`define POLYBLEP_OSC_ADSR_VOICE_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PBAV_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pbav: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define PBAV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pbav: next-cycle check failed");

`endif

[design/pbav_pkg.sv]
// Shared types, constants and helper functions for the polyBLEP voice core.
// No dependencies; imported by every module of the block.
package pbav_pkg;

    localparam int PHASE_BITS_DEF = 24;
    localparam int OUT_BITS_DEF   = 16;

    localparam int ENV_W   = 25;
    localparam int INC_W   = 24;
    localparam int SHAPE_W = 17;
    localparam int STAGE_W = 3;
    localparam int CFG_IDX_W = 3;

    localparam logic [ENV_W-1:0]   ENV_ONE   = 25'd16777216;
    localparam logic [SHAPE_W-1:0] SHAPE_ONE = 17'd65536;

    // Envelope stage codes.
    localparam logic [STAGE_W-1:0] ST_IDLE = 3'd0;
    localparam logic [STAGE_W-1:0] ST_ATK  = 3'd1;
    localparam logic [STAGE_W-1:0] ST_DEC  = 3'd2;
    localparam logic [STAGE_W-1:0] ST_SUS  = 3'd3;
    localparam logic [STAGE_W-1:0] ST_REL  = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHAPE   = 3'd4;

    // Status of an iterative arithmetic unit as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } pbav_unit_stat_t;

    // Clamp a Q0.24 register value to one.
    function automatic logic [ENV_W-1:0] sat_one(input logic [ENV_W-1:0] v);
        return (v > ENV_ONE) ? ENV_ONE : v;
    endfunction

    // Envelope step: clamped to one, and never zero.
    function automatic logic [ENV_W-1:0] step_of(input logic [ENV_W-1:0] v);
        logic [ENV_W-1:0] s;
        s = sat_one(v);
        return (s == '0) ? ENV_W'(1) : s;
    endfunction

endpackage

[design/pbav_div.sv]
// Radix-2 restoring divider, one quotient bit per clock.
// Depends on pbav_pkg; used by the voice core for the polyBLEP ratio.
module pbav_div
    import pbav_pkg::*;
#(
    parameter int PHASE_BITS = PHASE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [PHASE_BITS-1:0] num,
    input  logic [PHASE_BITS-1:0] den,
    output logic [PHASE_BITS-1:0] quo,
    output pbav_unit_stat_t       stat
);

    localparam int CW = $clog2(PHASE_BITS + 1);

    logic [PHASE_BITS-1:0] rem_reg, rem_next;
    logic [PHASE_BITS-1:0] den_reg, den_next;
    logic [PHASE_BITS-1:0] quo_reg, quo_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic [PHASE_BITS:0]   shifted;
    logic [PHASE_BITS:0]   trial;
    logic                  ge;

    // The numerator is always below the divisor, so the partial remainder
    // fits the phase width after every step.
    assign shifted = {rem_reg, 1'b0};
    assign trial   = shifted - {1'b0, den_reg};
    assign ge      = (shifted >= {1'b0, den_reg});

    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = num;
            den_next  = den;
            quo_next  = '0;
            cnt_next  = CW'(PHASE_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? trial[PHASE_BITS-1:0] : shifted[PHASE_BITS-1:0];
            quo_next = {quo_reg[PHASE_BITS-2:0], ge};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign quo       = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

[design/pbav_mul.sv]
// Shared signed multiplier with a registered product.
// Depends on pbav_pkg; used for the blep square and the shape morph.
module pbav_mul
    import pbav_pkg::*;
#(
    parameter int AW = PHASE_BITS_DEF + 4,
    parameter int BW = PHASE_BITS_DEF + 1
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic signed [AW-1:0]        a,
    input  logic signed [BW-1:0]        b,
    output logic signed [AW+BW-1:0]     prod,
    output logic                        done
);

    logic signed [AW+BW-1:0] prod_reg, prod_next;
    logic                    done_reg;

    always_comb
    begin
        prod_next = start ? (AW+BW)'(a * b) : prod_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;
    assign done = done_reg;

endmodule

[design/polyblep_osc_adsr_voice_core.sv]
// Top level of the polyBLEP saw/square oscillator with linear ADSR envelope.
// Depends on pbav_pkg, pbav_div, pbav_mul and the assertion macro header.
//
// One input transaction is one audio sample tick carrying the gate level and
// a Q0.24 phase increment; one output transaction carries the Q1.15 (in
// general Q1.(OUT_BITS-1)) saturated oscillator sample, the Q0.24 envelope
// level after this tick and the envelope stage. The envelope and the phase
// accumulator are updated in the cycle the input transaction is taken. The
// oscillator is then worked out by a small sequencer around two shared
// units: a radix-2 divider that produces one quotient bit per clock and a
// registered multiplier. Each polyBLEP correction that applies, near one of
// the two wrap points, adds a run of the divider and, unless the weight is a
// full one, a squaring on the multiplier before the morph. The input is
// stalled while a sample is being computed; a finished result sits in the
// output register, so the next input transaction can be taken while it waits.
// The configuration port is always ready and its registers should only be
// written while no sample is in flight.
`include "polyblep_osc_adsr_voice_core_assert.svh"

module polyblep_osc_adsr_voice_core
    import pbav_pkg::*;
#(
    parameter int PHASE_BITS = PHASE_BITS_DEF,
    parameter int OUT_BITS   = OUT_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    // Sample tick input channel.
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       gate_on,
    input  logic [INC_W-1:0]           phase_inc,
    // Result channel.
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [OUT_BITS-1:0] osc_sample,
    output logic [ENV_W-1:0]           env_level,
    output logic [STAGE_W-1:0]         env_phase,
    // Configuration write channel.
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [ENV_W-1:0]           cfg_data
);

    // Working width for the oscillator terms: values up to a few times one.
    localparam int W   = PHASE_BITS + 4;
    // Second multiplier operand must hold both the blep weight and the shape.
    localparam int MB  = (PHASE_BITS + 1 > SHAPE_W + 1) ? PHASE_BITS + 1 : SHAPE_W + 1;
    localparam int PW  = W + MB;
    localparam int ISH_L = (PHASE_BITS >= INC_W) ? PHASE_BITS - INC_W : 0;
    localparam int ISH_R = (PHASE_BITS >= INC_W) ? 0 : INC_W - PHASE_BITS;
    localparam int RSH = (PHASE_BITS >= OUT_BITS - 1) ? PHASE_BITS - (OUT_BITS - 1) : 0;
    localparam int LSH = (PHASE_BITS >= OUT_BITS - 1) ? 0 : (OUT_BITS - 1) - PHASE_BITS;
    localparam int YW  = W + LSH;

    localparam logic [PHASE_BITS:0]          ONE_P = {1'b1, {PHASE_BITS{1'b0}}};
    localparam logic [PHASE_BITS-1:0]        HALF  = {1'b1, {(PHASE_BITS-1){1'b0}}};
    localparam logic signed [W-1:0]          ONE_W = W'(ONE_P);
    localparam logic signed [YW-1:0]         OMAX  = YW'((64'sd1 <<< (OUT_BITS - 1)) - 64'sd1);
    localparam logic signed [YW-1:0]         OMIN  = YW'(-(64'sd1 <<< (OUT_BITS - 1)));

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_BLEP = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_SQGO = 3'd3;
    localparam logic [2:0] S_SQR  = 3'd4;
    localparam logic [2:0] S_MIX  = 3'd5;
    localparam logic [2:0] S_MIXW = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [ENV_W-1:0]   attack_reg, attack_next;
    logic [ENV_W-1:0]   decay_reg, decay_next;
    logic [ENV_W-1:0]   release_reg, release_next;
    logic [ENV_W-1:0]   sustain_reg, sustain_next;
    logic [SHAPE_W-1:0] shape_reg, shape_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        attack_next  = attack_reg;
        decay_next   = decay_reg;
        release_next = release_reg;
        sustain_next = sustain_reg;
        shape_next   = shape_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ATTACK:  attack_next  = cfg_data;
                CFG_DECAY:   decay_next   = cfg_data;
                CFG_RELEASE: release_next = cfg_data;
                CFG_SUSTAIN: sustain_next = cfg_data;
                CFG_SHAPE:   shape_next   = cfg_data[SHAPE_W-1:0];
                default:     ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Per-sample state and the sequencer registers.
    // ------------------------------------------------------------------
    logic [2:0]            state_reg, state_next;
    logic [PHASE_BITS-1:0] osc_phase_reg, osc_phase_next;
    logic [ENV_W-1:0]      env_value_reg, env_value_next;
    logic [STAGE_W-1:0]    env_stage_reg, env_stage_next;
    logic                  gate_prev_reg, gate_prev_next;

    logic [PHASE_BITS-1:0] t_reg, t_next;
    logic [PHASE_BITS-1:0] dt_reg, dt_next;
    logic                  k_reg, k_next;
    logic                  neg_reg, neg_next;
    logic [PHASE_BITS-1:0] w_reg, w_next;
    logic signed [W-1:0]   b0_reg, b0_next;
    logic signed [W-1:0]   b1_reg, b1_next;
    logic signed [OUT_BITS-1:0] res_reg, res_next;

    logic                       out_valid_reg, out_valid_next;
    logic signed [OUT_BITS-1:0] osc_out_reg, osc_out_next;
    logic [ENV_W-1:0]           env_out_reg, env_out_next;
    logic [STAGE_W-1:0]         stage_out_reg, stage_out_next;

    logic accept;
    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;

    // ------------------------------------------------------------------
    // Envelope update for the incoming tick. A rising gate restarts attack
    // from the present level; a falling gate starts release.
    // ------------------------------------------------------------------
    logic [STAGE_W-1:0]   stage_edge;
    logic [ENV_W-1:0]     sus_lvl;
    logic [ENV_W:0]       atk_sum;
    logic signed [ENV_W+1:0] dec_dif;
    logic signed [ENV_W+1:0] rel_dif;
    logic [ENV_W-1:0]     env_upd;
    logic [STAGE_W-1:0]   stage_upd;

    assign sus_lvl = sat_one(sustain_reg);
    assign atk_sum = {1'b0, env_value_reg} + {1'b0, step_of(attack_reg)};
    assign dec_dif = $signed({2'b00, env_value_reg}) - $signed({2'b00, step_of(decay_reg)});
    assign rel_dif = $signed({2'b00, env_value_reg}) - $signed({2'b00, step_of(release_reg)});

    always_comb
    begin
        stage_edge = env_stage_reg;
        if (gate_on && !gate_prev_reg)
        begin
            stage_edge = ST_ATK;
        end
        else if (!gate_on && gate_prev_reg)
        begin
            stage_edge = ST_REL;
        end

        env_upd   = env_value_reg;
        stage_upd = stage_edge;
        case (stage_edge)
            ST_ATK:
            begin
                if (atk_sum >= {1'b0, ENV_ONE})
                begin
                    env_upd   = ENV_ONE;
                    stage_upd = ST_DEC;
                end
                else
                begin
                    env_upd = atk_sum[ENV_W-1:0];
                end
            end
            ST_DEC:
            begin
                // Decay also lands on sustain when it starts below it.
                if (dec_dif <= $signed({2'b00, sus_lvl}))
                begin
                    env_upd   = sus_lvl;
                    stage_upd = ST_SUS;
                end
                else
                begin
                    env_upd = dec_dif[ENV_W-1:0];
                end
            end
            ST_SUS:
            begin
                env_upd = sus_lvl;
            end
            ST_REL:
            begin
                if (rel_dif <= 0)
                begin
                    env_upd   = '0;
                    stage_upd = ST_IDLE;
                end
                else
                begin
                    env_upd = rel_dif[ENV_W-1:0];
                end
            end
            default:
            begin
                env_upd   = '0;
                stage_upd = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Phase increment rescaled to the accumulator width, at most one half.
    // ------------------------------------------------------------------
    logic [PHASE_BITS+INC_W-1:0] dt_wide;
    logic [PHASE_BITS-1:0]       dt_raw;
    logic [PHASE_BITS-1:0]       dt_in;

    assign dt_wide = ((PHASE_BITS + INC_W)'(phase_inc) << ISH_L) >> ISH_R;
    assign dt_raw  = dt_wide[PHASE_BITS-1:0];
    assign dt_in   = (dt_raw > HALF) ? HALF : dt_raw;

    // ------------------------------------------------------------------
    // Blep region test for the phase under work: the plain phase first,
    // then the phase shifted by one half for the square's edge at mid-period.
    // ------------------------------------------------------------------
    logic [PHASE_BITS-1:0] tk;
    logic [PHASE_BITS:0]   tk_rest;
    logic                  lo_hit;
    logic                  hi_hit;
    logic [PHASE_BITS-1:0] blep_num;

    assign tk       = k_reg ? (t_reg ^ HALF) : t_reg;
    assign tk_rest  = ONE_P - {1'b0, tk};
    assign lo_hit   = (dt_reg != '0) && (tk < dt_reg);
    assign hi_hit   = (dt_reg != '0) && (tk_rest < {1'b0, dt_reg});
    assign blep_num = lo_hit ? tk : tk_rest[PHASE_BITS-1:0];

    // ------------------------------------------------------------------
    // Shared units.
    // ------------------------------------------------------------------
    logic                  div_start;
    logic [PHASE_BITS-1:0] div_quo;
    pbav_unit_stat_t       div_stat;

    pbav_div #(
        .PHASE_BITS(PHASE_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (blep_num),
        .den   (dt_reg),
        .quo   (div_quo),
        .stat  (div_stat)
    );

    logic                  mul_start;
    logic signed [W-1:0]   mul_a;
    logic signed [MB-1:0]  mul_b;
    logic signed [PW-1:0]  mul_prod;
    logic                  mul_done;

    pbav_mul #(
        .AW(W),
        .BW(MB)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .prod  (mul_prod),
        .done  (mul_done)
    );

    // ------------------------------------------------------------------
    // Saw, square and their morph.
    // ------------------------------------------------------------------
    logic signed [W-1:0]   t_w;
    logic signed [W-1:0]   saw;
    logic signed [W-1:0]   sq;
    logic signed [W-1:0]   mix_dif;
    logic [SHAPE_W-1:0]    shp;
    logic signed [W-1:0]   osc;
    logic signed [YW-1:0]  osc_ext;
    logic signed [YW-1:0]  y_full;
    logic signed [OUT_BITS-1:0] y_sat;
    logic signed [W-1:0]   blep_mag;

    assign t_w     = $signed({{(W-PHASE_BITS){1'b0}}, t_reg});
    assign saw     = (t_w <<< 1) - ONE_W - b0_reg;
    assign sq      = (t_reg[PHASE_BITS-1] ? -ONE_W : ONE_W) + b0_reg - b1_reg;
    assign mix_dif = sq - saw;
    assign shp     = (shape_reg > SHAPE_ONE) ? SHAPE_ONE : shape_reg;

    // Arithmetic right shift of the product floors the morph term.
    assign osc     = saw + mul_prod[16 +: W];
    assign osc_ext = YW'(osc);
    assign y_full  = (osc_ext >>> RSH) <<< LSH;

    always_comb
    begin
        if (y_full > OMAX)
        begin
            y_sat = OMAX[OUT_BITS-1:0];
        end
        else if (y_full < OMIN)
        begin
            y_sat = OMIN[OUT_BITS-1:0];
        end
        else
        begin
            y_sat = y_full[OUT_BITS-1:0];
        end
    end

    // Square of the blep weight, floored to the phase's fraction bits.
    assign blep_mag = $signed({{(W-PHASE_BITS){1'b0}}, mul_prod[PHASE_BITS +: PHASE_BITS]});

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    logic                b_wr;
    logic signed [W-1:0] b_val;

    always_comb
    begin
        state_next     = state_reg;
        osc_phase_next = osc_phase_reg;
        env_value_next = env_value_reg;
        env_stage_next = env_stage_reg;
        gate_prev_next = gate_prev_reg;
        t_next         = t_reg;
        dt_next        = dt_reg;
        k_next         = k_reg;
        neg_next       = neg_reg;
        w_next         = w_reg;
        res_next       = res_reg;
        div_start      = 1'b0;
        mul_start      = 1'b0;
        mul_a          = mix_dif;
        mul_b          = $signed({{(MB-SHAPE_W){1'b0}}, shp});
        b_wr           = 1'b0;
        b_val          = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    env_value_next = env_upd;
                    env_stage_next = stage_upd;
                    gate_prev_next = gate_on;
                    t_next         = osc_phase_reg;
                    dt_next        = dt_in;
                    osc_phase_next = osc_phase_reg + dt_in;
                    k_next         = 1'b0;
                    state_next     = S_BLEP;
                end
            end
            S_BLEP:
            begin
                if (lo_hit || hi_hit)
                begin
                    div_start  = 1'b1;
                    neg_next   = lo_hit;
                    state_next = S_DIV;
                end
                else
                begin
                    b_wr = 1'b1;
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    if (div_quo == '0)
                    begin
                        // Exactly on the edge the weight is a full one.
                        b_wr  = 1'b1;
                        b_val = neg_reg ? -ONE_W : ONE_W;
                    end
                    else
                    begin
                        w_next     = ONE_P[PHASE_BITS-1:0] - div_quo;
                        state_next = S_SQGO;
                    end
                end
            end
            S_SQGO:
            begin
                mul_start  = 1'b1;
                mul_a      = $signed({{(W-PHASE_BITS){1'b0}}, w_reg});
                mul_b      = $signed({{(MB-PHASE_BITS){1'b0}}, w_reg});
                state_next = S_SQR;
            end
            S_SQR:
            begin
                if (mul_done)
                begin
                    b_wr  = 1'b1;
                    b_val = neg_reg ? -blep_mag : blep_mag;
                end
            end
            S_MIX:
            begin
                mul_start  = 1'b1;
                state_next = S_MIXW;
            end
            S_MIXW:
            begin
                if (mul_done)
                begin
                    res_next   = y_sat;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Store a blep term and move on to the next edge or to the morph.
        if (b_wr)
        begin
            if (k_reg)
            begin
                state_next = S_MIX;
            end
            else
            begin
                k_next     = 1'b1;
                state_next = S_BLEP;
            end
        end
    end

    assign b0_next = (b_wr && !k_reg) ? b_val : b0_reg;
    assign b1_next = (b_wr && k_reg)  ? b_val : b1_reg;

    // ------------------------------------------------------------------
    // Output register: loaded when the result is ready and the slot is free.
    // ------------------------------------------------------------------
    logic out_load;

    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        osc_out_next   = osc_out_reg;
        env_out_next   = env_out_reg;
        stage_out_next = stage_out_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            osc_out_next   = res_reg;
            env_out_next   = env_value_reg;
            stage_out_next = env_stage_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg    <= 25'd69905;
            decay_reg     <= 25'd524;
            release_reg   <= 25'd1165;
            sustain_reg   <= 25'd11744051;
            shape_reg     <= 17'd9830;
            state_reg     <= S_IDLE;
            osc_phase_reg <= '0;
            env_value_reg <= '0;
            env_stage_reg <= ST_IDLE;
            gate_prev_reg <= 1'b0;
            k_reg         <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            attack_reg    <= attack_next;
            decay_reg     <= decay_next;
            release_reg   <= release_next;
            sustain_reg   <= sustain_next;
            shape_reg     <= shape_next;
            state_reg     <= state_next;
            osc_phase_reg <= osc_phase_next;
            env_value_reg <= env_value_next;
            env_stage_reg <= env_stage_next;
            gate_prev_reg <= gate_prev_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg         <= t_next;
        dt_reg        <= dt_next;
        neg_reg       <= neg_next;
        w_reg         <= w_next;
        b0_reg        <= b0_next;
        b1_reg        <= b1_next;
        res_reg       <= res_next;
        osc_out_reg   <= osc_out_next;
        env_out_reg   <= env_out_next;
        stage_out_reg <= stage_out_next;
    end

    assign out_valid  = out_valid_reg;
    assign osc_sample = osc_out_reg;
    assign env_level  = env_out_reg;
    assign env_phase  = stage_out_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // A transaction taken at the input always starts a computation.
    `PBAV_ASSERT_NEXT(a_accept_starts, accept, in_stall)
    // The divider only ever runs while the sequencer waits for it.
    `PBAV_ASSERT_NOW(a_div_owned, div_stat.busy, state_reg == S_DIV)
    // An envelope reported idle is silent.
    `PBAV_ASSERT_NOW(a_idle_silent, out_valid && (env_phase == ST_IDLE), env_level == '0)

endmodule
